### rtl/core/mspw_pkg.sv
// Shared types and constants for the square wave melody player.
package mspw_pkg;

    localparam int NOTE_DEPTH = 256;
    localparam int TICK_US    = 1000;
    localparam int HALF_NUM   = 500000;

    localparam int ADDR_W   = 8;
    localparam int FIELD_W  = 16;
    localparam int MEM_AW   = $clog2(NOTE_DEPTH);
    localparam int WORD_W   = 2 * FIELD_W;
    localparam int HALF_W   = $clog2(HALF_NUM + 1);
    localparam int PHASE_W  = $clog2(64'((1 << FIELD_W) - 1) * 64'(TICK_US) + 64'd1);
    localparam int DIV_NUM_W = (PHASE_W > HALF_W) ? PHASE_W : HALF_W;
    localparam int DIV_DEN_W = HALF_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

endpackage

### rtl/core/mspw_note_mem.sv
// Note memory: one write port, one registered read port.
module mspw_note_mem (
    input  logic                          aclk,
    input  mspw_pkg::mem_wr_t             wr,
    input  logic [mspw_pkg::MEM_AW-1:0]   raddr,
    output logic [mspw_pkg::WORD_W-1:0]   rdata
);

    logic [mspw_pkg::WORD_W-1:0] mem [mspw_pkg::NOTE_DEPTH];
    logic [mspw_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mspw_div.sv
// Restoring divider, one quotient bit per cycle.
module mspw_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mspw_pkg::div_req_t              req,
    output logic                            done,
    output logic [mspw_pkg::DIV_NUM_W-1:0]  quot
);

    localparam int NW = mspw_pkg::DIV_NUM_W;
    localparam int DW = mspw_pkg::DIV_DEN_W;
    localparam int CW = mspw_pkg::DIV_CNT_W;

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[NW-1]};
        diff      = trial - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/core/melody_square_wave_player_unit.sv
// Top level of the square wave melody player: command sequencer and result register.
//
// Input channel s_*: one request per command (tick of 1 ms, write note, start at an
// address, stop). The command code travels in s_tuser, the note fields in s_tdata.
// Result channel m_*: one result per request with speaker level, playing flag,
// current note address and an end-of-melody flag set only for the ending request.
// A request passes from idle through the load state when a note is read, the half
// state while the divider forms the half period of a new note, the eval state, the
// phase state while the divider forms the phase, and the fin state that registers
// the result and returns to idle, where the next request is taken; a state with
// nothing to do is skipped. The run time of a request is set by the shared
// bit-serial divider, one quotient bit per cycle over 26 bits: one pass for the
// phase of the square wave, and one more for the half period when a note is loaded.
// One request is worked at a time; s_tready is high while the sequencer is idle,
// also while the previous result still waits on m_tready.
// Reset clears playback state and the result channel; the note memory keeps no
// reset value and a note must be written before it is played.
// A stalled receiver holds the result; the next request is taken, but its result
// waits in the sequencer until the result register is free.
module melody_square_wave_player_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // note_addr[7:0], note_freq[23:8], note_dur[39:24]
    input  logic [mspw_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // speaker_on[0], playing[1], current_note[9:2], melody_done[10], zeros above
    output logic [mspw_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int AW = mspw_pkg::ADDR_W;
    localparam int FW = mspw_pkg::FIELD_W;
    localparam int HW = mspw_pkg::HALF_W;
    localparam int PW = mspw_pkg::PHASE_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_HALF  = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_PHASE = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic            playing_reg, playing_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [FW-1:0]   freq_reg, freq_next;
    logic [FW-1:0]   dur_reg, dur_next;
    logic [FW-1:0]   elapsed_reg, elapsed_next;
    logic [HW-1:0]   half_reg, half_next;
    logic            speaker_reg, speaker_next;
    logic            done_reg, done_next;
    logic            m_valid_reg, m_valid_next;
    logic [mspw_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    mspw_pkg::cmd_t     cmd;
    logic [AW-1:0]      in_addr;
    logic [FW-1:0]      in_freq;
    logic [FW-1:0]      in_dur;
    logic               accept;
    logic [FW-1:0]      elapsed_inc;
    logic [AW:0]        next_addr;
    logic [PW-1:0]      phase;
    logic [FW-1:0]      rd_freq;
    logic [FW-1:0]      rd_dur;

    mspw_pkg::mem_wr_t               mem_wr;
    logic [mspw_pkg::WORD_W-1:0]     mem_rdata;
    mspw_pkg::div_req_t              div_req;
    logic                            div_done;
    logic [mspw_pkg::DIV_NUM_W-1:0]  div_quot;

    mspw_note_mem u_mem (
        .aclk  (aclk),
        .wr    (mem_wr),
        .raddr (mspw_pkg::MEM_AW'(rd_addr_next)),
        .rdata (mem_rdata)
    );

    mspw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign cmd      = mspw_pkg::cmd_t'(s_tuser);
    assign in_addr  = s_tdata[AW-1:0];
    assign in_freq  = s_tdata[AW+FW-1:AW];
    assign in_dur   = s_tdata[AW+2*FW-1:AW+FW];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign elapsed_inc = (elapsed_reg != {FW{1'b1}}) ? elapsed_reg + FW'(1) : elapsed_reg;
    assign next_addr   = {1'b0, ptr_reg} + (AW+1)'(1);
    assign phase       = PW'(elapsed_reg) * PW'(mspw_pkg::TICK_US);
    assign rd_freq     = mem_rdata[2*FW-1:FW];
    assign rd_dur      = mem_rdata[FW-1:0];

    always_comb begin
        state_next   = state_reg;
        playing_next = playing_reg;
        ptr_next     = ptr_reg;
        rd_addr_next = rd_addr_reg;
        freq_next    = freq_reg;
        dur_next     = dur_reg;
        elapsed_next = elapsed_reg;
        half_next    = half_reg;
        speaker_next = speaker_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = mspw_pkg::MEM_AW'(in_addr);
        mem_wr.data  = {in_freq, in_dur};
        div_req.start = 1'b0;
        div_req.num   = mspw_pkg::DIV_NUM_W'(phase);
        div_req.den   = half_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    done_next  = 1'b0;
                    state_next = ST_EVAL;
                    case (cmd)
                        mspw_pkg::CMD_TICK: begin
                            if (playing_reg) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= dur_reg) begin
                                    if (32'(next_addr) >= mspw_pkg::NOTE_DEPTH ||
                                        next_addr[AW]) begin
                                        playing_next = 1'b0;
                                        done_next    = 1'b1;
                                    end else begin
                                        rd_addr_next = next_addr[AW-1:0];
                                        state_next   = ST_LOAD;
                                    end
                                end
                            end
                        end
                        mspw_pkg::CMD_WRITE: begin
                            mem_wr.en = (32'(in_addr) < mspw_pkg::NOTE_DEPTH);
                        end
                        mspw_pkg::CMD_START: begin
                            if (32'(in_addr) >= mspw_pkg::NOTE_DEPTH) begin
                                playing_next = 1'b0;
                                done_next    = 1'b1;
                            end else begin
                                rd_addr_next = in_addr;
                                state_next   = ST_LOAD;
                            end
                        end
                        mspw_pkg::CMD_STOP: begin
                            playing_next = 1'b0;
                        end
                        default: begin
                            playing_next = playing_reg;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                ptr_next     = rd_addr_reg;
                freq_next    = rd_freq;
                dur_next     = rd_dur;
                elapsed_next = '0;
                state_next   = ST_EVAL;
                if (rd_freq == '0 && rd_dur == '0) begin
                    playing_next = 1'b0;
                    done_next    = 1'b1;
                end else begin
                    playing_next = 1'b1;
                    if (rd_freq != '0) begin
                        div_req.start = 1'b1;
                        div_req.num   = mspw_pkg::DIV_NUM_W'(mspw_pkg::HALF_NUM);
                        div_req.den   = mspw_pkg::DIV_DEN_W'(rd_freq);
                        state_next    = ST_HALF;
                    end
                end
            end
            ST_HALF: begin
                if (div_done) begin
                    half_next  = div_quot[HW-1:0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!playing_reg || freq_reg == '0 || dur_reg == '0 || half_reg == '0) begin
                    speaker_next = 1'b0;
                    state_next   = ST_FIN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (div_done) begin
                    speaker_next = ~div_quot[0];
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mspw_pkg::M_DATA_W'({done_reg, ptr_reg, playing_reg,
                                                        speaker_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            playing_reg <= 1'b0;
            ptr_reg     <= '0;
            freq_reg    <= '0;
            dur_reg     <= '0;
            elapsed_reg <= '0;
            half_reg    <= '0;
            speaker_reg <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            playing_reg <= playing_next;
            ptr_reg     <= ptr_next;
            freq_reg    <= freq_next;
            dur_reg     <= dur_next;
            elapsed_reg <= elapsed_next;
            half_reg    <= half_next;
            speaker_reg <= speaker_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
